FILE: hw/rtl/joystick_tilt_orientation_command_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the joystick tilt orientation core
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_TILT_ORIENTATION_COMMAND_CORE_ASSERT_SVH
`define JOYSTICK_TILT_ORIENTATION_COMMAND_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define JTOC_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define JTOC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/jtoc_pkg.sv
// ----------------------------------------------------------------------------
// jtoc_pkg
// Shared types, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package jtoc_pkg;

	localparam int DW = 34;

	// datapath word: angles in degrees * 2^16, trig values in Q30
	typedef logic signed [DW-1:0] dval_t;

	localparam dval_t DEG90    = 34'sd5898240;
	localparam dval_t DEG180   = 34'sd11796480;
	localparam dval_t DEG360   = 34'sd23592960;
	localparam dval_t CORDIC_K = 34'sd652032874;

	// register indexes on the config port
	localparam logic [1:0] REG_GAIN = 2'd0;
	localparam logic [1:0] REG_STEP = 2'd1;

	// item operation codes
	localparam logic OP_JOY  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic start;
		logic vec;
	} cordic_cmd_t;

	// atan(2^-i) in degrees * 2^16
	function automatic dval_t atan_deg16(input logic [4:0] i);
		dval_t r;
		case (i)
			5'd0: r = 34'sd2949120;
			5'd1: r = 34'sd1740967;
			5'd2: r = 34'sd919879;
			5'd3: r = 34'sd466945;
			5'd4: r = 34'sd234379;
			5'd5: r = 34'sd117304;
			5'd6: r = 34'sd58666;
			5'd7: r = 34'sd29335;
			5'd8: r = 34'sd14668;
			5'd9: r = 34'sd7334;
			5'd10: r = 34'sd3667;
			5'd11: r = 34'sd1833;
			5'd12: r = 34'sd917;
			5'd13: r = 34'sd458;
			5'd14: r = 34'sd229;
			5'd15: r = 34'sd115;
			5'd16: r = 34'sd57;
			5'd17: r = 34'sd29;
			5'd18: r = 34'sd14;
			5'd19: r = 34'sd7;
			5'd20: r = 34'sd4;
			5'd21: r = 34'sd2;
			5'd22: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/jtoc_cordic.sv
// ----------------------------------------------------------------------------
// jtoc_cordic
// Iterative CORDIC, one micro-rotation per cycle: sin/cos or atan2.
// ----------------------------------------------------------------------------
module jtoc_cordic #(
	parameter int ITER = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jtoc_pkg::cordic_cmd_t cmd,
	input  jtoc_pkg::dval_t      x_in,
	input  jtoc_pkg::dval_t      y_in,
	input  jtoc_pkg::dval_t      z_in,
	output logic                 done,
	output jtoc_pkg::dval_t      x_out,
	output jtoc_pkg::dval_t      y_out,
	output jtoc_pkg::dval_t      z_out
);
	import jtoc_pkg::*;

	localparam int IW = $clog2(ITER);

	dval_t          x_q, y_q, z_q;
	logic [IW-1:0]  i_q;
	logic           busy_q, neg_q, vec_q, done_q;

	dval_t zw, zr, xs, ys, at;
	logic  fold_hi, fold_lo, d;

	always_comb begin
		// range reduce to -90..90, remember a half-turn fold
		zw      = (z_in >= DEG180) ? z_in - DEG360 : z_in;
		fold_hi = zw > DEG90;
		fold_lo = zw < -DEG90;
		zr      = fold_hi ? zw - DEG180 : (fold_lo ? zw + DEG180 : zw);
		xs      = x_q >>> i_q;
		ys      = y_q >>> i_q;
		at      = atan_deg16(5'(i_q));
		// d: counter-clockwise micro-rotation
		d       = vec_q ? y_q[DW-1] : ~z_q[DW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			vec_q  <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start && !busy_q) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				vec_q  <= cmd.vec;
				if (cmd.vec) begin
					neg_q <= 1'b0;
					if (x_in[DW-1]) begin
						x_q <= y_in;
						y_q <= -x_in;
						z_q <= DEG90;
					end else begin
						x_q <= x_in;
						y_q <= y_in;
						z_q <= '0;
					end
				end else begin
					x_q   <= CORDIC_K;
					y_q   <= '0;
					z_q   <= zr;
					neg_q <= fold_hi | fold_lo;
				end
			end else if (busy_q) begin
				if (d) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
				if (i_q == IW'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign x_out = neg_q ? -x_q : x_q;
	assign y_out = neg_q ? -y_q : y_q;
	assign z_out = z_q;

endmodule

FILE: hw/rtl/jtoc_isqrt.sv
// ----------------------------------------------------------------------------
// jtoc_isqrt
// Bit-serial floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module jtoc_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] n,
	output logic        done,
	output logic [31:0] root
);
	import jtoc_pkg::*;

	logic [63:0] rem_q, res_q, bit_q, trial;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q, ge;

	assign trial = res_q + bit_q;
	assign ge    = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= n;
				res_q  <= '0;
				bit_q  <= 64'h4000_0000_0000_0000;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

FILE: hw/rtl/joystick_tilt_orientation_command_core.sv
// ----------------------------------------------------------------------------
// joystick_tilt_orientation_command_core
// Joystick-driven tilt/spin state with cone limit and quaternion output.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, always ready): index 0 writes the
//   joystick gain, index 1 the spin step; other indexes are dropped.
//   item channel (item_valid/item_ready): operation 0 is a joystick item
//   (axes and buttons), operation 1 a tick that returns one quaternion item
//   on the result channel (result_valid/result_ready).
//   One item is worked at a time; item_ready is high only when idle.
//   Items use the single shared CORDIC unit, the 64-bit root unit and one
//   32x32 multiplier in turn: a tick takes three CORDIC rotations and
//   twelve products; a joystick item two rotations and two products, and
//   with cone pull two roots and two atan runs besides. A home press is
//   handled in the idle state.
//   The result sits in an output register; the core takes new items while it
//   waits, and a following tick holds in its last step until it is taken.
//   Reset: tilts at 90 degrees, spin 0, gain 4, step 4, no result pending.
// ----------------------------------------------------------------------------
module joystick_tilt_orientation_command_core #(
	parameter int CORDIC_ITERATIONS = 16,
	parameter int ANGLE_FRAC_BITS   = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               operation,
	input  logic signed [15:0] axis_left_right,
	input  logic signed [15:0] axis_up_down,
	input  logic               button_spin_up,
	input  logic               button_spin_down,
	input  logic               button_home,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w
);
	import jtoc_pkg::*;

	localparam int F   = ANGLE_FRAC_BITS;
	localparam int TW  = 8 + F;       // tilt width, holds 135 degrees
	localparam int SH  = 15 - F;      // tilt LSB to half-angle deg16
	localparam int TSH = 16 - F;      // tilt LSB to deg16

	typedef logic [TW-1:0] tilt_t;

	localparam dval_t T45     = 34'sd45 <<< F;
	localparam dval_t T90     = 34'sd90 <<< F;
	localparam dval_t T135    = 34'sd135 <<< F;
	localparam dval_t ROUND_T = 34'sd1 <<< (TSH - 1);

	localparam logic [63:0] CONE_LIM  = 64'd1 << 59;   // 0.5 in Q60
	localparam logic [10:0] SPIN_WRAP = 11'd720;
	localparam logic [3:0]  M_SQ_LAST = 4'd1;
	localparam logic [3:0]  M_Q_FIRST = 4'd2;
	localparam logic [3:0]  M_Q_LAST  = 4'd13;

	typedef enum logic [3:0] {
		S_IDLE, S_COR_GO, S_COR_WAIT, S_MUL_GO, S_MUL_PUT, S_CONE,
		S_SQ_GO, S_SQ_WAIT, S_AT_GO, S_AT_WAIT, S_OUT
	} state_t;

	function automatic tilt_t clamp_tilt(input dval_t v);
		dval_t r;
		r = (v < T45) ? T45 : ((v > T135) ? T135 : v);
		return r[TW-1:0];
	endfunction

	// round Q30 to Q15 and saturate
	function automatic logic signed [15:0] to_q15(input dval_t v);
		logic signed [34:0] w;
		w = ($signed({v[DW-1], v}) + 35'sd16384) >>> 15;
		if (w > 35'sd32767)
			return 16'sh7FFF;
		else if (w < -35'sd32768)
			return 16'sh8000;
		else
			return w[15:0];
	endfunction

	state_t              state_q;
	logic                op_q;
	logic [1:0]          k_q;
	logic [3:0]          m_q;
	tilt_t               tilt_a_q, tilt_b_q, na_q, nb_q;
	logic [9:0]          spin_q;
	logic [5:0]          gain_q;
	logic [7:0]          step_q;
	logic signed [31:0]  s_q [3];
	logic signed [31:0]  c_q [3];
	logic [63:0]         sq_q [2];
	logic [31:0]         root_q [2];
	logic signed [31:0]  l1_q [4];    // x1, y1, z1, w1
	dval_t               acc_q;
	logic signed [15:0]  res_q [4];
	logic signed [63:0]  prod_q;
	logic signed [15:0]  quat_q [4];
	logic                rvalid_q;

	// joystick step
	logic signed [22:0] m_lr, m_ud;
	dval_t              a_raw, b_raw;
	logic [10:0]        sp1, sp_dn;
	logic [9:0]         spin_s1, spin_new;

	// shared units
	cordic_cmd_t        cor_cmd;
	dval_t              cor_x_in, cor_y_in, cor_z_in, cor_x, cor_y, cor_z;
	logic               cor_done;
	logic               sq_start, sq_done;
	logic [63:0]        sq_n;
	logic [31:0]        sq_root;

	// multiplier
	logic signed [31:0] ma, mb;
	logic signed [63:0] mul_p, pr;
	dval_t              mq, nmq, comb_v, zt;
	logic [63:0]        cone_sum;

	always_comb begin
		m_lr  = $signed({1'b0, gain_q}) * axis_left_right;
		m_ud  = $signed({1'b0, gain_q}) * axis_up_down;
		a_raw = dval_t'(tilt_a_q) + dval_t'(m_lr >>> SH);
		b_raw = dval_t'(tilt_b_q) - dval_t'(m_ud >>> SH);

		// spin: up first, then down, both wrap at 720
		sp1     = {1'b0, spin_q} + 11'(step_q);
		spin_s1 = button_spin_up ? ((sp1 >= SPIN_WRAP) ? 10'(sp1 - SPIN_WRAP) : sp1[9:0])
		                         : spin_q;
		sp_dn   = {1'b0, spin_s1} + SPIN_WRAP - 11'(step_q);
		spin_new = button_spin_down ? ((sp_dn >= SPIN_WRAP) ? 10'(sp_dn - SPIN_WRAP)
		                                                   : sp_dn[9:0])
		                            : spin_s1;
	end

	// CORDIC operand select
	always_comb begin
		cor_cmd.start = (state_q == S_COR_GO) || (state_q == S_AT_GO);
		cor_cmd.vec   = (state_q == S_AT_GO);
		cor_x_in      = dval_t'(c_q[k_q]);
		cor_y_in      = dval_t'(root_q[k_q[0]]);
		cor_z_in      = '0;
		if (op_q == OP_JOY) begin
			cor_z_in = k_q[0] ? (dval_t'(nb_q) <<< TSH) : (dval_t'(na_q) <<< TSH);
		end else begin
			case (k_q)
				2'd0:    cor_z_in = (dval_t'(tilt_b_q) - T90) <<< SH;   // half roll
				2'd1:    cor_z_in = (T90 - dval_t'(tilt_a_q)) <<< SH;   // half pitch
				default: cor_z_in = dval_t'(spin_q) <<< 15;            // half yaw
			endcase
		end
	end

	// root operands: S + S - c^2 for each axis
	assign sq_start = (state_q == S_SQ_GO);
	assign sq_n     = k_q[0] ? ((sq_q[0] << 1) + sq_q[1]) : (sq_q[0] + (sq_q[1] << 1));
	assign cone_sum = sq_q[0] + sq_q[1];

	// multiply schedule
	always_comb begin
		case (m_q)
			4'd0:    begin ma = c_q[0];  mb = c_q[0];  end   // ca^2
			4'd1:    begin ma = c_q[1];  mb = c_q[1];  end   // cb^2
			4'd2:    begin ma = s_q[0];  mb = c_q[1];  end   // x1
			4'd3:    begin ma = c_q[0];  mb = s_q[1];  end   // y1
			4'd4:    begin ma = s_q[0];  mb = s_q[1];  end   // -z1
			4'd5:    begin ma = c_q[0];  mb = c_q[1];  end   // w1
			4'd6:    begin ma = l1_q[1]; mb = c_q[2];  end
			4'd7:    begin ma = l1_q[0]; mb = s_q[2];  end
			4'd8:    begin ma = l1_q[0]; mb = c_q[2];  end
			4'd9:    begin ma = l1_q[1]; mb = s_q[2];  end
			4'd10:   begin ma = l1_q[3]; mb = s_q[2];  end
			4'd11:   begin ma = l1_q[2]; mb = c_q[2];  end
			4'd12:   begin ma = l1_q[3]; mb = c_q[2];  end
			4'd13:   begin ma = l1_q[2]; mb = s_q[2];  end
			default: begin ma = '0;      mb = '0;      end
		endcase
		mul_p = ma * mb;
		pr    = prod_q + 64'sd536870912;
		mq    = pr[63:30];
		nmq   = -mq;
		case (m_q)
			4'd7:    comb_v = mq - acc_q;   // -(y1 cy - x1 sy)
			4'd13:   comb_v = acc_q - mq;   // w1 cy - z1 sy
			default: comb_v = acc_q + mq;
		endcase
		zt = (cor_z + ROUND_T) >>> TSH;
	end

	jtoc_cordic #(
		.ITER (CORDIC_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cor_cmd),
		.x_in   (cor_x_in),
		.y_in   (cor_y_in),
		.z_in   (cor_z_in),
		.done   (cor_done),
		.x_out  (cor_x),
		.y_out  (cor_y),
		.z_out  (cor_z)
	);

	jtoc_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.n      (sq_n),
		.done   (sq_done),
		.root   (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_JOY;
			k_q      <= '0;
			m_q      <= '0;
			tilt_a_q <= T90[TW-1:0];
			tilt_b_q <= T90[TW-1:0];
			spin_q   <= '0;
			gain_q   <= 6'd4;
			step_q   <= 8'd4;
			rvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_GAIN: gain_q <= cfg_data[5:0];
					REG_STEP: step_q <= cfg_data;
					default:  ;
				endcase
			end

			// a new result loads when none is pending or as the pending one leaves
			if ((state_q == S_OUT) && (!rvalid_q || result_ready))
				rvalid_q <= 1'b1;
			else if (rvalid_q && result_ready)
				rvalid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						op_q <= operation;
						k_q  <= '0;
						if (operation == OP_TICK) begin
							state_q <= S_COR_GO;
						end else if (button_home) begin
							tilt_a_q <= T90[TW-1:0];
							tilt_b_q <= T90[TW-1:0];
							spin_q   <= '0;
						end else begin
							spin_q  <= spin_new;
							na_q    <= clamp_tilt(a_raw);
							nb_q    <= clamp_tilt(b_raw);
							state_q <= S_COR_GO;
						end
					end
				end
				S_COR_GO: begin
					state_q <= S_COR_WAIT;
				end
				S_COR_WAIT: begin
					if (cor_done) begin
						s_q[k_q] <= cor_y[31:0];
						c_q[k_q] <= cor_x[31:0];
						if (k_q == ((op_q == OP_TICK) ? 2'd2 : 2'd1)) begin
							m_q     <= (op_q == OP_TICK) ? M_Q_FIRST : 4'd0;
							state_q <= S_MUL_GO;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= S_COR_GO;
						end
					end
				end
				S_MUL_GO: begin
					prod_q  <= mul_p;
					state_q <= S_MUL_PUT;
				end
				S_MUL_PUT: begin
					case (m_q)
						4'd0:    sq_q[0]  <= prod_q;
						4'd1:    sq_q[1]  <= prod_q;
						4'd2:    l1_q[0]  <= mq[31:0];
						4'd3:    l1_q[1]  <= mq[31:0];
						4'd4:    l1_q[2]  <= nmq[31:0];
						4'd5:    l1_q[3]  <= mq[31:0];
						4'd7:    res_q[0] <= to_q15(comb_v);
						4'd9:    res_q[1] <= to_q15(comb_v);
						4'd11:   res_q[2] <= to_q15(comb_v);
						4'd13:   res_q[3] <= to_q15(comb_v);
						default: acc_q    <= mq;
					endcase
					if (m_q == M_SQ_LAST) begin
						state_q <= S_CONE;
					end else if (m_q == M_Q_LAST) begin
						state_q <= S_OUT;
					end else begin
						m_q     <= m_q + 4'd1;
						state_q <= S_MUL_GO;
					end
				end
				S_CONE: begin
					// exactly 0.5 stays put
					if (cone_sum > CONE_LIM) begin
						k_q     <= '0;
						state_q <= S_SQ_GO;
					end else begin
						tilt_a_q <= na_q;
						tilt_b_q <= nb_q;
						state_q  <= S_IDLE;
					end
				end
				S_SQ_GO: begin
					state_q <= S_SQ_WAIT;
				end
				S_SQ_WAIT: begin
					if (sq_done) begin
						root_q[k_q[0]] <= sq_root;
						if (k_q[0]) begin
							k_q     <= '0;
							state_q <= S_AT_GO;
						end else begin
							k_q     <= 2'd1;
							state_q <= S_SQ_GO;
						end
					end
				end
				S_AT_GO: begin
					state_q <= S_AT_WAIT;
				end
				S_AT_WAIT: begin
					if (cor_done) begin
						if (k_q[0]) begin
							tilt_b_q <= clamp_tilt(zt);
							state_q  <= S_IDLE;
						end else begin
							tilt_a_q <= clamp_tilt(zt);
							k_q      <= 2'd1;
							state_q  <= S_AT_GO;
						end
					end
				end
				S_OUT: begin
					// hold here while an earlier result is still pending
					if (!rvalid_q || result_ready) begin
						quat_q  <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready    = 1'b1;
	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = rvalid_q;
	assign quat_x       = quat_q[0];
	assign quat_y       = quat_q[1];
	assign quat_z       = quat_q[2];
	assign quat_w       = quat_q[3];

`include "joystick_tilt_orientation_command_core_assert.svh"

	`JTOC_ASSERT_HOLDS(a_tilt_a_range, (dval_t'(tilt_a_q) >= T45) && (dval_t'(tilt_a_q) <= T135), "tilt_a outside 45..135")
	`JTOC_ASSERT_HOLDS(a_spin_range, spin_q < 10'd720, "spin angle not wrapped")
	`JTOC_ASSERT_IMPLIES(a_cor_done, cor_done, (state_q == S_COR_WAIT) || (state_q == S_AT_WAIT), "CORDIC done while not waiting")
	`JTOC_ASSERT_IMPLIES(a_sq_done, sq_done, state_q == S_SQ_WAIT, "root done while not waiting")

endmodule
